// ===== hw/rtl/tun_pkg.sv =====
package tun_pkg;

	// coordinate and result formats
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 14;
	localparam int OUT_W      = 16;

	// derived datapath widths
	localparam int EW  = COORD_BITS + 1;   // edge vector component
	localparam int PW  = 2 * EW;           // edge product
	localparam int NW  = PW + 1;           // cross product component, signed
	localparam int MW  = NW;               // cross product magnitude
	localparam int HB  = (MW + 1) / 2;     // low half of a magnitude for squaring
	localparam int AW  = MW - HB;          // high half
	localparam int SQW = 2 * MW;           // one square
	localparam int SW  = SQW + 2;          // sum of three squares
	localparam int LW  = SW / 2;           // root (length)
	localparam int DS  = FRAC_BITS + 1;    // quotient bits, one per divider stage

	// queue between front and back
	localparam int QD  = 4;
	localparam int QAW = $clog2(QD);

	// valid chain of the back: two square stages, sum, root stages, divider stages
	localparam int NV = 3 + LW + DS;

	localparam logic [DS-1:0] LIM = DS'(1) << FRAC_BITS;

	// three corners by three axes
	typedef logic [2:0][2:0][COORD_BITS-1:0] crd_t;

	// classified cross product handed from front to back
	typedef struct packed {
		logic [2:0][MW-1:0] mag;
		logic [2:0]         neg;
		logic               degen;
	} ctx_t;

endpackage

// ===== hw/rtl/tun_front.sv =====
module tun_front import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  crd_t crd,
	output logic out_vld,
	output ctx_t out_ctx,
	input  logic out_rdy
);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	crd_t crd_s1;
	logic signed [EW-1:0] u_c [3];
	logic signed [EW-1:0] v_c [3];
	logic signed [EW-1:0] u_s2 [3];
	logic signed [EW-1:0] v_s2 [3];
	logic signed [PW-1:0] pr_s3 [6];
	logic signed [NW-1:0] n_s4 [3];
	ctx_t ctx_s5;

	// advance the whole front unless the last request is held back by the queue
	assign en      = !vld_s5 || out_rdy;
	assign full    = !en;
	assign out_vld = vld_s5;
	assign out_ctx = ctx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// form the edge vectors from the first corner to the second and the third
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			u_c[a] = EW'(signed'(crd_s1[1][a])) - EW'(signed'(crd_s1[0][a]));
			v_c[a] = EW'(signed'(crd_s1[2][a])) - EW'(signed'(crd_s1[0][a]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s1 <= crd;
			for (int a = 0; a < 3; a++) begin
				u_s2[a] <= u_c[a];
				v_s2[a] <= v_c[a];
			end
			// cross product terms
			pr_s3[0] <= u_s2[1] * v_s2[2];
			pr_s3[1] <= u_s2[2] * v_s2[1];
			pr_s3[2] <= u_s2[2] * v_s2[0];
			pr_s3[3] <= u_s2[0] * v_s2[2];
			pr_s3[4] <= u_s2[0] * v_s2[1];
			pr_s3[5] <= u_s2[1] * v_s2[0];
			n_s4[0]  <= NW'(pr_s3[0]) - NW'(pr_s3[1]);
			n_s4[1]  <= NW'(pr_s3[2]) - NW'(pr_s3[3]);
			n_s4[2]  <= NW'(pr_s3[4]) - NW'(pr_s3[5]);
			// classify: split sign and magnitude, flag a zero normal
			for (int c = 0; c < 3; c++) begin
				ctx_s5.mag[c] <= n_s4[c][NW-1] ? MW'(-n_s4[c]) : MW'(n_s4[c]);
				ctx_s5.neg[c] <= n_s4[c][NW-1];
			end
			ctx_s5.degen <= (n_s4[0] == '0) && (n_s4[1] == '0) && (n_s4[2] == '0);
		end
	end

endmodule

// ===== hw/rtl/tun_queue.sv =====
module tun_queue import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ctx_t push_data,
	output logic full,
	input  logic pop,
	output ctx_t head,
	output logic empty
);

	ctx_t mem_q [QD];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0] cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QD));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// store a request at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QD))
		else $error("queue count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

endmodule

// ===== hw/rtl/tun_back.sv =====
module tun_back import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  ctx_t in_ctx,
	output logic in_take,
	output logic empty,
	input  logic pop,
	output logic signed [OUT_W-1:0] normal_x,
	output logic signed [OUT_W-1:0] normal_y,
	output logic signed [OUT_W-1:0] normal_z,
	output logic degenerate
);

	logic en;
	logic [NV-1:0] vld_q;
	logic ovld_q;

	logic [2*AW-1:0]   aa_s1 [3];
	logic [AW+HB-1:0]  ab_s1 [3];
	logic [2*HB-1:0]   bb_s1 [3];
	ctx_t              ctx_s1;
	logic [SQW-1:0]    sq_s2 [3];
	ctx_t              ctx_s2;
	logic [SW-1:0]     sum_s3;
	ctx_t              ctx_s3;

	logic [SW-1:0]     rt_src_q [LW];
	logic [LW:0]       rt_rem_q [LW];
	logic [LW-1:0]     rt_res_q [LW];
	ctx_t              rt_ctx_q [LW];

	logic [2:0][LW-1:0] dv_rem_q [DS];
	logic [2:0][DS-1:0] dv_quo_q [DS];
	logic [LW-1:0]      dv_len_q [DS];
	ctx_t               dv_ctx_q [DS];

	logic [DS-1:0]       qc [3];
	logic signed [DS+1:0] sv [3];
	logic signed [OUT_W-1:0] nrm_q [3];
	logic degen_q;

	// stall the back as one piece while the result register is held
	assign en      = !ovld_q || pop;
	assign in_take = en && in_vld;
	assign empty   = !ovld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			ovld_q <= 1'b0;
		end else if (en) begin
			vld_q  <= {vld_q[NV-2:0], in_take};
			ovld_q <= vld_q[NV-1];
		end
	end

	// square each magnitude from half-width partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				aa_s1[c] <= in_ctx.mag[c][MW-1:HB] * in_ctx.mag[c][MW-1:HB];
				ab_s1[c] <= in_ctx.mag[c][MW-1:HB] * in_ctx.mag[c][HB-1:0];
				bb_s1[c] <= in_ctx.mag[c][HB-1:0] * in_ctx.mag[c][HB-1:0];
				sq_s2[c] <= (SQW'(aa_s1[c]) << (2*HB)) + (SQW'(ab_s1[c]) << (HB+1))
					+ SQW'(bb_s1[c]);
			end
			ctx_s1 <= in_ctx;
			ctx_s2 <= ctx_s1;
			sum_s3 <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
			ctx_s3 <= ctx_s2;
		end
	end

	// floor square root, one root bit per stage
	for (genvar k = 0; k < LW; k++) begin : g_rt
		logic [SW-1:0] src_i;
		logic [LW:0]   rem_i;
		logic [LW-1:0] res_i;
		ctx_t          ctx_i;
		logic [LW+2:0] cur, trial, dif;
		logic          ge;

		if (k == 0) begin : g_src
			assign src_i = sum_s3;
			assign rem_i = '0;
			assign res_i = '0;
			assign ctx_i = ctx_s3;
		end else begin : g_src
			assign src_i = rt_src_q[k-1];
			assign rem_i = rt_rem_q[k-1];
			assign res_i = rt_res_q[k-1];
			assign ctx_i = rt_ctx_q[k-1];
		end

		assign cur   = {rem_i, src_i[SW-1 -: 2]};
		assign trial = {1'b0, res_i, 2'b01};
		assign ge    = cur >= trial;
		assign dif   = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_src_q[k] <= src_i << 2;
				rt_rem_q[k] <= ge ? dif[LW:0] : cur[LW:0];
				rt_res_q[k] <= {res_i[LW-2:0], ge};
				rt_ctx_q[k] <= ctx_i;
			end
		end
	end

	// restoring divide of each magnitude by the length, one quotient bit per stage
	for (genvar j = 0; j < DS; j++) begin : g_dv
		logic [LW-1:0]      len_i;
		logic [2:0][LW-1:0] rem_i;
		logic [2:0][DS-1:0] quo_i;
		ctx_t               ctx_i;
		logic [2:0][LW:0]   cur;
		logic [2:0]         ge;

		if (j == 0) begin : g_src
			assign len_i = rt_res_q[LW-1];
			assign ctx_i = rt_ctx_q[LW-1];
			assign quo_i = '0;
			assign rem_i = {LW'(rt_ctx_q[LW-1].mag[2]), LW'(rt_ctx_q[LW-1].mag[1]),
				LW'(rt_ctx_q[LW-1].mag[0])};
		end else begin : g_src
			assign len_i = dv_len_q[j-1];
			assign ctx_i = dv_ctx_q[j-1];
			assign quo_i = dv_quo_q[j-1];
			assign rem_i = dv_rem_q[j-1];
		end

		// the integer bit takes the remainder unshifted
		always_comb begin
			for (int c = 0; c < 3; c++) begin
				cur[c] = (j == 0) ? {1'b0, rem_i[c]} : {rem_i[c], 1'b0};
				ge[c]  = cur[c] >= {1'b0, len_i};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					dv_rem_q[j][c] <= ge[c] ? LW'(cur[c] - {1'b0, len_i}) : LW'(cur[c]);
					dv_quo_q[j][c] <= {quo_i[c][DS-2:0], ge[c]};
				end
				dv_len_q[j] <= len_i;
				dv_ctx_q[j] <= ctx_i;
			end
		end
	end

	// clamp, restore the sign, zero a degenerate normal
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qc[c] = (dv_quo_q[DS-1][c] > LIM) ? LIM : dv_quo_q[DS-1][c];
			sv[c] = dv_ctx_q[DS-1].neg[c] ? -signed'({2'b00, qc[c]})
				: signed'({2'b00, qc[c]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				nrm_q[c] <= dv_ctx_q[DS-1].degen ? '0 : OUT_W'(sv[c]);
			end
			degen_q <= dv_ctx_q[DS-1].degen;
		end
	end

	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];
	assign degenerate = degen_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result with nonzero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> normal_x <= signed'(OUT_W'(LIM)) && normal_x >= -signed'(OUT_W'(LIM))
			&& normal_y <= signed'(OUT_W'(LIM)) && normal_y >= -signed'(OUT_W'(LIM))
			&& normal_z <= signed'(OUT_W'(LIM)) && normal_z >= -signed'(OUT_W'(LIM)))
		else $error("normal component beyond unit range");

	a_take_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> vld_q[0])
		else $error("taken request lost at back entry");

endmodule

// ===== hw/rtl/triangle_unit_normal_top.sv =====
// Unit surface normal of a triangle. Push the three corners (signed 16-bit
// coordinates) while full is low; the result (normal_x/y/z in signed Q1.14,
// within +/-16384, and degenerate) appears when empty is low and leaves on pop.
// One triangle is accepted every cycle and results come back in order, one per
// cycle, when nothing stalls. The back end holds a 36-stage square root
// pipeline, one root bit per stage, followed by a 15-stage divider, one quotient
// bit per stage. A five-stage front forms edges and the cross product and flags
// a zero normal; a four-entry queue between front and back lets each side stall
// on its own. A degenerate triangle gives zero components with degenerate set.
// No configuration, no reset-time initialization pass.
module triangle_unit_normal_top import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	input  logic signed [COORD_BITS-1:0] third_x,
	input  logic signed [COORD_BITS-1:0] third_y,
	input  logic signed [COORD_BITS-1:0] third_z,
	output logic empty,
	input  logic pop,
	output logic signed [OUT_W-1:0] normal_x,
	output logic signed [OUT_W-1:0] normal_y,
	output logic signed [OUT_W-1:0] normal_z,
	output logic degenerate
);

	crd_t crd;
	logic f_vld, q_full, q_empty, take;
	ctx_t f_ctx, q_head;

	// gather corners by corner and axis
	assign crd[0][0] = first_x;
	assign crd[0][1] = first_y;
	assign crd[0][2] = first_z;
	assign crd[1][0] = second_x;
	assign crd[1][1] = second_y;
	assign crd[1][2] = second_z;
	assign crd[2][0] = third_x;
	assign crd[2][1] = third_y;
	assign crd[2][2] = third_z;

	tun_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.crd     (crd),
		.out_vld (f_vld),
		.out_ctx (f_ctx),
		.out_rdy (!q_full)
	);

	tun_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_vld && !q_full),
		.push_data (f_ctx),
		.full      (q_full),
		.pop       (take),
		.head      (q_head),
		.empty     (q_empty)
	);

	tun_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (!q_empty),
		.in_ctx     (q_head),
		.in_take    (take),
		.empty      (empty),
		.pop        (pop),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z),
		.degenerate (degenerate)
	);

endmodule

// ===== sim/normal_checker.sv =====
`timescale 1ns / 100ps

module normal_checker import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	input  logic signed [COORD_BITS-1:0] third_x,
	input  logic signed [COORD_BITS-1:0] third_y,
	input  logic signed [COORD_BITS-1:0] third_z,
	input  logic empty,
	input  logic pop,
	input  logic signed [OUT_W-1:0] normal_x,
	input  logic signed [OUT_W-1:0] normal_y,
	input  logic signed [OUT_W-1:0] normal_z,
	input  logic degenerate,
	output int   errors,
	output int   pending,
	output int   degen_seen
);

	typedef struct packed {
		logic [OUT_W-1:0] nx;
		logic [OUT_W-1:0] ny;
		logic [OUT_W-1:0] nz;
		logic             dg;
	} normal_t;

	normal_t expected_normals[$];

	// floor square root of a 128-bit value, bit by bit
	function automatic logic [63:0] isqrt(logic [127:0] v);
		logic [63:0]  root;
		logic [63:0]  trial;
		int           b;
		root = '0;
		for (b = 63; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if ({64'd0, trial} * {64'd0, trial} <= v)
				root = trial;
		end
		return root;
	endfunction

	// scale one component to Q1.FRAC_BITS, truncate toward zero, clamp
	function automatic logic [OUT_W-1:0] scale(longint c, logic [63:0] len);
		logic [127:0] num;
		logic [127:0] q;
		logic [63:0]  m;
		m = (c < 0) ? 64'(-c) : 64'(c);
		num = {64'd0, m} << FRAC_BITS;
		q = num / {64'd0, len};
		if (q > (128'd1 << FRAC_BITS))
			q = 128'd1 << FRAC_BITS;
		if (c < 0)
			q = -q;
		return q[OUT_W-1:0];
	endfunction

	function automatic normal_t unit_normal(longint p1x, longint p1y, longint p1z,
			longint p2x, longint p2y, longint p2z, longint p3x, longint p3y,
			longint p3z);
		longint      ux, uy, uz, vx, vy, vz, cx, cy, cz;
		logic [127:0] ax, ay, az;
		logic [127:0] sum;
		logic [63:0]  len;
		normal_t      r;
		ux = p2x - p1x; uy = p2y - p1y; uz = p2z - p1z;
		vx = p3x - p1x; vy = p3y - p1y; vz = p3z - p1z;
		cx = uy * vz - uz * vy;
		cy = uz * vx - ux * vz;
		cz = ux * vy - uy * vx;
		// square the magnitudes at full width
		ax = {64'd0, ((cx < 0) ? 64'(-cx) : 64'(cx))};
		ay = {64'd0, ((cy < 0) ? 64'(-cy) : 64'(cy))};
		az = {64'd0, ((cz < 0) ? 64'(-cz) : 64'(cz))};
		sum = ax * ax + ay * ay + az * az;
		len = isqrt(sum);
		if (len == 0)
			r = '{nx: '0, ny: '0, nz: '0, dg: 1'b1};
		else
			r = '{nx: scale(cx, len), ny: scale(cy, len), nz: scale(cz, len), dg: 1'b0};
		return r;
	endfunction

	// predict on each accepted request, compare on each accepted result
	always @(posedge clk) begin
		normal_t e;
		if (arst_n && push && !full)
			expected_normals.push_back(unit_normal(first_x, first_y, first_z,
				second_x, second_y, second_z, third_x, third_y, third_z));
		if (arst_n && pop && !empty) begin
			if (expected_normals.size() == 0) begin
				errors++;
				$display("%0t: result with no request waiting: %h %h %h %b", $time,
					normal_x, normal_y, normal_z, degenerate);
			end else begin
				e = expected_normals.pop_front();
				if (degenerate) degen_seen++;
				if (e.nx !== normal_x || e.ny !== normal_y || e.nz !== normal_z
						|| e.dg !== degenerate) begin
					errors++;
					$display("%0t: mismatch expected %0d %0d %0d deg %b, actual %0d %0d %0d deg %b",
						$time, $signed(e.nx), $signed(e.ny), $signed(e.nz), e.dg,
						normal_x, normal_y, normal_z, degenerate);
				end
			end
		end
		pending <= expected_normals.size();
	end

	initial begin
		errors = 0;
		pending = 0;
		degen_seen = 0;
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import tun_pkg::*;

	localparam int WATCHDOG = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, degenerate;
	logic signed [COORD_BITS-1:0] crd [9];
	logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
	int errors, pending, degen_seen;
	int idle_pct = 24;
	int sent = 0;
	int stalled = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	triangle_unit_normal_top DUT (
		.clk, .arst_n, .push, .full,
		.first_x(crd[0]), .first_y(crd[1]), .first_z(crd[2]),
		.second_x(crd[3]), .second_y(crd[4]), .second_z(crd[5]),
		.third_x(crd[6]), .third_y(crd[7]), .third_z(crd[8]),
		.empty, .pop, .normal_x, .normal_y, .normal_z, .degenerate
	);

	normal_checker u_check (
		.clk, .arst_n, .push, .full,
		.first_x(crd[0]), .first_y(crd[1]), .first_z(crd[2]),
		.second_x(crd[3]), .second_y(crd[4]), .second_z(crd[5]),
		.third_x(crd[6]), .third_y(crd[7]), .third_z(crd[8]),
		.empty, .pop, .normal_x, .normal_y, .normal_z, .degenerate,
		.errors, .pending, .degen_seen
	);

	// pick a random coordinate set; kind selects the triangle shape
	task automatic random_triangle(output logic [COORD_BITS-1:0] t [9]);
		int kind;
		int s;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) t[i] = COORD_BITS'($urandom());
		case (kind)
			0: for (int i = 3; i < 9; i++) t[i] = t[i % 3];
			1: begin
				// collinear: third = first + s * (second - first)
				s = $urandom_range(0, 3);
				for (int i = 0; i < 3; i++) begin
					t[i] = COORD_BITS'(int'($urandom_range(0, 255)) - 128);
					t[i + 3] = COORD_BITS'(int'(t[i]) + int'($urandom_range(0, 63)) - 32);
					t[i + 6] = COORD_BITS'(int'(t[i]) + s * (int'(t[i + 3]) - int'(t[i])));
				end
			end
			2: for (int i = 0; i < 9; i++)
				t[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			3: for (int i = 0; i < 9; i++)
				t[i] = COORD_BITS'(int'($urandom_range(0, 6)) - 3);
			default: ;
		endcase
	endtask

	// hold each request until accepted
	task automatic send(input logic [COORD_BITS-1:0] t [9]);
		while ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		for (int i = 0; i < 9; i++) crd[i] <= t[i];
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	// result side stalls at random
	always @(posedge clk)
		pop <= ($urandom_range(0, 99) >= idle_pct);

	// count cycles with no accepted request or result
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stalled <= 0;
		else
			stalled <= stalled + 1;
		if (stalled >= WATCHDOG) begin
			$display("watchdog expired, %0d results outstanding", pending);
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		logic [COORD_BITS-1:0] t [9];
		for (int i = 0; i < 9; i++) crd[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: zeros, extremes, unit axes, degenerate shapes
		for (int d = 0; d < 20; d++) begin
			for (int i = 0; i < 9; i++) t[i] = '0;
			case (d)
				0: ;
				1: for (int i = 0; i < 9; i++) t[i] = 16'h7fff;
				2: begin t[3] = 16'd1; t[7] = 16'd1; end
				3: begin t[4] = 16'd1; t[8] = 16'd1; end
				4: begin t[5] = 16'd1; t[6] = 16'd1; end
				5: begin t[3] = 16'h7fff; t[7] = 16'h7fff; end
				6: begin t[0] = 16'h8000; t[1] = 16'h8000; t[2] = 16'h8000;
					t[3] = 16'h7fff; t[7] = 16'h7fff; t[8] = 16'h7fff; end
				7: begin t[0] = 16'h7fff; t[3] = 16'h8000; t[4] = 16'h7fff;
					t[5] = 16'h8000; t[6] = 16'h8000; t[7] = 16'h8000; t[8] = 16'h7fff; end
				8: begin t[3] = 16'd5; t[4] = 16'd5; t[6] = 16'd10; t[7] = 16'd10; end
				9: begin t[3] = 16'hffff; t[7] = 16'hffff; t[8] = 16'd1; end
				default: random_triangle(t);
			endcase
			send(t);
		end

		// random phase; the middle stretch runs with no idling
		for (int n = 0; n < 1250; n++) begin
			idle_pct = (n >= 500 && n < 700) ? 0 : 24;
			random_triangle(t);
			send(t);
		end
		push <= 1'b0;
		idle_pct = 24;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d triangles, %0d came back degenerate", sent, degen_seen);
		$display("with random stalls on both sides and a full-rate stretch");
		if (errors == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
